@@ sv/lru_kvc_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, codes, beat types and control struct.
// ----------------------------------------------------------------------------
package lru_kvc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic             MODE_GET   = 1'b0;
    localparam logic             MODE_PUT   = 1'b1;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] store_value;
    } t_req;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic hit;      // key present
        logic touch;    // target slot becomes most recent
        logic write;    // target slot takes key and value
        logic grow;     // occupancy goes up by one
        logic age_all;  // every other valid slot ages
    } t_ctl;

endpackage

@@ sv/lru_key_value_cache_core.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative key-value store with least-recently-used replacement.
// Output: a get result is registered in the result register once its beat
// leaves the input register; a put beat produces no result.
// Throughput: one beat per cycle while the result is not stalled; a lookup
// and its rank update are combinational between input and result registers.
// Reset: synchronous; valid marks, ranks and occupancy clear at once, no
// clearing pass; capacity returns to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
    parameter int ENTRIES = lru_kvc_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lru_kvc_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lru_kvc_pkg::t_req               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lru_kvc_pkg::t_rsp               o_out_data
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);

    logic [lru_kvc_pkg::KEY_W-1:0]   r_keys  [ENTRIES];
    logic [lru_kvc_pkg::VAL_W-1:0]   r_vals  [ENTRIES];
    logic [RANK_W-1:0]               r_ranks [ENTRIES];
    logic [ENTRIES-1:0]              r_valid;
    logic [OCC_W-1:0]                r_occ;
    logic [lru_kvc_pkg::CAP_W-1:0]   r_cap;
    logic                            r_in_valid;
    lru_kvc_pkg::t_req               r_in;
    logic                            r_out_valid;
    lru_kvc_pkg::t_rsp               r_out;

    logic [ENTRIES-1:0]              target;
    logic [RANK_W-1:0]               old_rank;
    logic [lru_kvc_pkg::VAL_W-1:0]   read_value;
    lru_kvc_pkg::t_ctl               ctl;
    logic                            advance;
    logic                            is_get;

    lru_kvc_lookup #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .OCC_W   (OCC_W)
    ) u_lookup (
        .i_req        (r_in),
        .i_cap        (r_cap),
        .i_occ        (r_occ),
        .i_valid      (r_valid),
        .i_keys       (r_keys),
        .i_vals       (r_vals),
        .i_ranks      (r_ranks),
        .o_target     (target),
        .o_old_rank   (old_rank),
        .o_read_value (read_value),
        .o_ctl        (ctl)
    );

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign is_get      = (r_in.mode == lru_kvc_pkg::MODE_GET);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= lru_kvc_pkg::CAP_RESET;
            r_occ       <= '0;
            r_valid     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && is_get) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && ctl.write) begin
                r_valid <= r_valid | target;
            end
            if (advance && ctl.grow) begin
                r_occ <= r_occ + 1'b1;
            end
        end
    end

    // recency ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_ranks[i] <= '0;
            end
        end else if (advance && ctl.touch) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (target[i]) begin
                    r_ranks[i] <= '0;
                end else if (r_valid[i] && (ctl.age_all || (r_ranks[i] < old_rank))) begin
                    r_ranks[i] <= r_ranks[i] + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance && is_get) begin
            r_out.found      <= ctl.hit;
            r_out.read_value <= read_value;
        end
        if (advance && ctl.write) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (target[i]) begin
                    r_keys[i] <= r_in.lookup_key;
                    r_vals[i] <= r_in.store_value;
                end
            end
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= ENTRIES)
        else $error("occupancy above entry count");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("valid marks disagree with occupancy");

    a_target_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(target))
        else $error("more than one target slot");

    a_get_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_get |=> r_out_valid)
        else $error("get beat lost its result");

    a_put_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !is_get && r_out_valid && i_out_ready |=> !r_out_valid)
        else $error("put beat produced a result");

endmodule

@@ sv/lru_kvc_lookup.sv @@
// ----------------------------------------------------------------------------
// LRU key-value cache lookup
// Parallel key match, victim and free-slot pick, hit value select.
// ----------------------------------------------------------------------------
module lru_kvc_lookup #(
    parameter int ENTRIES = lru_kvc_pkg::ENTRIES_DEF,
    parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int OCC_W   = $clog2(ENTRIES + 1)
) (
    input  lru_kvc_pkg::t_req                   i_req,
    input  logic [lru_kvc_pkg::CAP_W-1:0]       i_cap,
    input  logic [OCC_W-1:0]                    i_occ,
    input  logic [ENTRIES-1:0]                  i_valid,
    input  logic [lru_kvc_pkg::KEY_W-1:0]       i_keys  [ENTRIES],
    input  logic [lru_kvc_pkg::VAL_W-1:0]       i_vals  [ENTRIES],
    input  logic [RANK_W-1:0]                   i_ranks [ENTRIES],
    output logic [ENTRIES-1:0]                  o_target,
    output logic [RANK_W-1:0]                   o_old_rank,
    output logic [lru_kvc_pkg::VAL_W-1:0]       o_read_value,
    output lru_kvc_pkg::t_ctl                   o_ctl
);

    localparam int CW = OCC_W + lru_kvc_pkg::CAP_W;

    logic [ENTRIES-1:0]              match;
    logic [ENTRIES-1:0]              victim;
    logic [ENTRIES-1:0]              free;
    logic [ENTRIES-1:0]              first_free;
    logic [RANK_W-1:0]               old_rank;
    logic [lru_kvc_pkg::VAL_W-1:0]   hit_val;
    logic [OCC_W-1:0]                occ_m1;
    logic [CW-1:0]                   cap_x;
    logic [CW-1:0]                   cap_eff;
    logic                            hit;
    logic                            over;
    logic                            is_put;

    always_comb begin
        occ_m1   = i_occ - 1'b1;
        old_rank = '0;
        hit_val  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = i_valid[i] && (i_keys[i] == i_req.lookup_key);
            victim[i] = i_valid[i] && (i_ranks[i] == RANK_W'(occ_m1));
            if (match[i]) begin
                old_rank = old_rank | i_ranks[i];
                hit_val  = hit_val | i_vals[i];
            end
        end
        free       = ~i_valid;
        first_free = free & (~free + ENTRIES'(1));
        hit        = |match;
        is_put     = (i_req.mode == lru_kvc_pkg::MODE_PUT);
        cap_x      = CW'(i_cap);
        cap_eff    = (cap_x > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_x;
        over       = (CW'(i_occ) + CW'(1)) > cap_eff;

        if (hit) begin
            o_target = match;
        end else if (over) begin
            o_target = (i_occ != '0) ? victim : '0;
        end else begin
            o_target = first_free;
        end

        o_ctl.hit     = hit;
        o_ctl.write   = is_put && (hit || !over || (i_occ != '0));
        o_ctl.touch   = hit || o_ctl.write;
        o_ctl.grow    = is_put && !hit && !over;
        o_ctl.age_all = !hit;

        o_old_rank   = old_rank;
        o_read_value = hit ? hit_val : lru_kvc_pkg::MISS_VALUE;
    end

endmodule
